[hdl/dsn_pkg.sv]
package dsn_pkg;

   // Datapath widths, sized for the largest supported sample count.
   localparam int SUM_W   = 38;
   localparam int SQ_W    = 51;
   localparam int MAG_W   = 36;
   localparam int DVD_W   = 72;
   localparam int DVS_W   = 21;
   localparam int RT_IN_W = 52;
   localparam int RT_W    = 26;
   localparam int INV_W   = 24;

   localparam logic [1:0] OP_ACCUM = 2'd0;
   localparam logic [1:0] OP_FINISH = 2'd1;
   localparam logic [1:0] OP_NORM = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_ZERO_VAR = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NO_STATS = 3'd4;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

[hdl/dsn_div.sv]
module dsn_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [dsn_pkg::DVD_W-1:0]   dividend,
   input  logic [dsn_pkg::DVS_W-1:0]   divisor,
   output dsn_pkg::unit_stat_type      stat,
   output logic [dsn_pkg::DVD_W-1:0]   quotient,
   output logic [dsn_pkg::DVS_W-1:0]   remainder
);
   import dsn_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DVS_W:0]   trial, trial_diff;
   logic             fits;

   // One restoring step per cycle: the quotient bit shifts into the dividend.
   always_comb begin
      trial      = {rem_ff, dvd_ff[DVD_W-1]};
      fits       = trial >= {1'b0, dvs_ff};
      trial_diff = trial - {1'b0, dvs_ff};
      rem_in     = fits ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_in     = {dvd_ff[DVD_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
   a_div_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dvs_ff || dvs_ff == '0)) else $error("remainder too large");
endmodule

[hdl/dsn_sqrt.sv]
module dsn_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [dsn_pkg::RT_IN_W-1:0]  radicand,
   output dsn_pkg::unit_stat_type       stat,
   output logic [dsn_pkg::RT_W-1:0]     root
);
   import dsn_pkg::*;

   localparam int CNT_W = $clog2(RT_W + 1);

   logic [RT_IN_W-1:0] rad_ff;
   logic [RT_W+1:0]    rem_ff, rem_in;
   logic [RT_W-1:0]    root_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff, done_ff;
   logic [RT_W+3:0]    cur, trial, cur_diff;
   logic               fits;

   // Two radicand bits and one root bit per cycle.
   always_comb begin
      cur      = {rem_ff, rad_ff[RT_IN_W-1 -: 2]};
      trial    = {2'b00, root_ff, 2'b01};
      fits     = cur >= trial;
      cur_diff = cur - trial;
      rem_in   = fits ? cur_diff[RT_W+1:0] : cur[RT_W+1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(RT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RT_IN_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= {root_ff[RT_W-2:0], fits};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = root_ff;
endmodule

[hdl/dsn_mul.sv]
module dsn_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [dsn_pkg::MAG_W-1:0]    mcand,
   input  logic [dsn_pkg::MAG_W-1:0]    mplier,
   output dsn_pkg::unit_stat_type       stat,
   output logic [2*dsn_pkg::MAG_W-1:0]  product
);
   import dsn_pkg::*;

   localparam int CNT_W = $clog2(MAG_W + 1);

   logic [2*MAG_W-1:0] acc_ff, mc_ff;
   logic [MAG_W-1:0]   mp_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff, done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(MAG_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift and add, one multiplier bit per cycle.
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         mc_ff  <= {{MAG_W{1'b0}}, mcand};
         mp_ff  <= mplier;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_ff <= acc_ff + mc_ff;
         end
         mc_ff <= {mc_ff[2*MAG_W-2:0], 1'b0};
         mp_ff <= {1'b0, mp_ff[MAG_W-1:1]};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;
endmodule

[hdl/density_std_normalizer.sv]
// Voxel density standardizer.
// Input channel req_*: an item carries an opcode and a signed Q8.8 sample.
// Accumulate adds the sample to the running statistics and gives no result
// unless the counter is full. Finish gives the mean and standard deviation
// and clears the accumulators; normalize gives (sample - mean) / std in Q8.8.
// Result channel rsp_*: one item per finish or normalize, or a status item.
// Throughput: accumulate takes one item per cycle while the counter is not
// full. Normalize runs a registered subtract, a registered multiply and the
// rounding stage. Finish makes four passes of the shared 72-step restoring
// divider and runs a 36-step shift-add square and a 26-step square root.
// With zero variance the last divide is skipped.
// req_stall is high while an item is in work. An item may be accepted while
// a result waits in the output register; a new result waits in its own
// staging register until the receiver drops rsp_stall.
// Reset (synchronous) clears the counters, the stored statistics and
// all valid flags.
module density_std_normalizer #(
   parameter int MAX_VOXELS = 1048576
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_value,
   output logic [15:0]        rsp_std_dev,
   output logic [2:0]         rsp_status
);
   import dsn_pkg::*;

   localparam int CNT_W = $clog2(MAX_VOXELS + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MEAN = 4'd1;
   localparam logic [3:0] S_SQR  = 4'd2;
   localparam logic [3:0] S_SQF  = 4'd3;
   localparam logic [3:0] S_VAR  = 4'd4;
   localparam logic [3:0] S_ROOT = 4'd5;
   localparam logic [3:0] S_INV  = 4'd6;
   localparam logic [3:0] S_NMUL = 4'd7;
   localparam logic [3:0] S_NRND = 4'd8;
   localparam logic [3:0] S_EMIT = 4'd9;

   logic [3:0]              state_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [SQ_W-1:0]         sq_ff;
   logic signed [15:0]      mean_ff;
   logic [INV_W-1:0]        inv_ff;
   logic                    ready_ff;
   logic                    rsp_valid_ff;
   logic [15:0]             rsp_value_ff, rsp_sd_ff;
   logic [2:0]              rsp_status_ff;
   logic [15:0]             res_value_ff, res_sd_ff;
   logic [2:0]              res_status_ff;
   logic [MAG_W-1:0]        mag_ff;
   logic signed [16:0]      d_ff;
   logic signed [41:0]      prod_ff;
   logic                    div_go_ff, mul_go_ff, sq_go_ff;
   logic [DVD_W-1:0]        div_a_ff;
   logic [DVS_W-1:0]        div_b_ff;

   unit_stat_type           div_st, mul_st, sq_st;
   logic [DVD_W-1:0]        quot;
   logic [DVS_W-1:0]        rem;
   logic [2*MAG_W-1:0]      sqr_prod;
   logic [RT_W-1:0]         root;

   logic                    req_fire, out_free;
   logic [DVS_W-1:0]        n_w;
   logic signed [31:0]      samp_sq;
   logic signed [SUM_W-1:0] neg_sum;
   logic [DVS_W:0]          rnd_sum;
   logic [MAG_W:0]          m_w;
   logic [15:0]             mean_w;
   logic [DVD_W-1:0]        diff_w;
   logic [15:0]             sd_w;
   logic [41:0]             pm_w;
   logic [25:0]             rm_w;
   logic [15:0]             nval_w;

   dsn_div u_div (
      .clock(clock), .reset(reset), .start(div_go_ff),
      .dividend(div_a_ff), .divisor(div_b_ff),
      .stat(div_st), .quotient(quot), .remainder(rem)
   );

   dsn_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_go_ff),
      .mcand(mag_ff), .mplier(mag_ff), .stat(mul_st), .product(sqr_prod)
   );

   dsn_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_go_ff),
      .radicand({{(RT_IN_W-SQ_W){1'b0}}, quot[SQ_W-1:0]}),
      .stat(sq_st), .root(root)
   );

   always_comb begin
      req_fire = req_valid && !req_stall;
      out_free = !rsp_valid_ff || !rsp_stall;
      n_w      = DVS_W'(cnt_ff);
      samp_sq  = req_sample * req_sample;
      neg_sum  = -sum_ff;
      // Round half away from zero: bump when the remainder reaches n/2.
      rnd_sum  = {1'b0, rem} + {2'b00, n_w[DVS_W-1:1]};
      m_w      = {1'b0, quot[MAG_W-1:0]} + (MAG_W+1)'(rnd_sum >= {1'b0, n_w});
      mean_w   = sum_ff[SUM_W-1] ? -m_w[15:0] : m_w[15:0];
      diff_w   = ({{(DVD_W-SQ_W){1'b0}}, sq_ff} > quot)
                 ? {{(DVD_W-SQ_W){1'b0}}, sq_ff} - quot : '0;
      sd_w     = (|root[RT_W-1:16]) ? 16'hFFFF : root[15:0];
      pm_w     = prod_ff[41] ? 42'(-prod_ff) : 42'(prod_ff);
      rm_w     = 26'((pm_w + 42'h8000) >> 16);
      if (prod_ff[41]) begin
         nval_w = (rm_w > 26'd32768) ? 16'h8000 : -rm_w[15:0];
      end else begin
         nval_w = (rm_w > 26'd32767) ? 16'h7FFF : rm_w[15:0];
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         mean_ff      <= '0;
         inv_ff       <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
         mul_go_ff    <= 1'b0;
         sq_go_ff     <= 1'b0;
      end else begin
         div_go_ff <= 1'b0;
         mul_go_ff <= 1'b0;
         sq_go_ff  <= 1'b0;
         // The emit state decides the valid flag on its own.
         if (!rsp_stall && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  case (req_op)
                     OP_ACCUM: begin
                        if (cnt_ff >= CNT_W'(MAX_VOXELS)) begin
                           res_value_ff  <= '0;
                           res_sd_ff     <= '0;
                           res_status_ff <= ST_FULL;
                           state_ff      <= S_EMIT;
                        end else begin
                           cnt_ff <= cnt_ff + 1'b1;
                           sum_ff <= sum_ff + {{(SUM_W-16){req_sample[15]}}, req_sample};
                           sq_ff  <= sq_ff + {{(SQ_W-32){1'b0}}, samp_sq};
                        end
                     end
                     OP_FINISH: begin
                        if (cnt_ff == '0) begin
                           res_value_ff  <= '0;
                           res_sd_ff     <= '0;
                           res_status_ff <= ST_EMPTY;
                           state_ff      <= S_EMIT;
                        end else begin
                           mag_ff    <= sum_ff[SUM_W-1] ? neg_sum[MAG_W-1:0]
                                                        : sum_ff[MAG_W-1:0];
                           div_a_ff  <= {{(DVD_W-MAG_W){1'b0}},
                                         sum_ff[SUM_W-1] ? neg_sum[MAG_W-1:0]
                                                         : sum_ff[MAG_W-1:0]};
                           div_b_ff  <= n_w;
                           div_go_ff <= 1'b1;
                           state_ff  <= S_MEAN;
                        end
                     end
                     OP_NORM: begin
                        if (!ready_ff) begin
                           res_value_ff  <= '0;
                           res_sd_ff     <= '0;
                           res_status_ff <= ST_NO_STATS;
                           state_ff      <= S_EMIT;
                        end else begin
                           d_ff     <= 17'(req_sample) - 17'(mean_ff);
                           state_ff <= S_NMUL;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_MEAN: begin
               if (div_st.done) begin
                  res_value_ff <= mean_w;
                  mul_go_ff    <= 1'b1;
                  state_ff     <= S_SQR;
               end
            end
            S_SQR: begin
               if (mul_st.done) begin
                  div_a_ff  <= sqr_prod;
                  div_go_ff <= 1'b1;
                  state_ff  <= S_SQF;
               end
            end
            S_SQF: begin
               if (div_st.done) begin
                  div_a_ff  <= diff_w;
                  div_go_ff <= 1'b1;
                  state_ff  <= S_VAR;
               end
            end
            S_VAR: begin
               if (div_st.done) begin
                  sq_go_ff <= 1'b1;
                  state_ff <= S_ROOT;
               end
            end
            S_ROOT: begin
               if (sq_st.done) begin
                  res_sd_ff <= sd_w;
                  if (sd_w == '0) begin
                     inv_ff        <= '0;
                     mean_ff       <= res_value_ff;
                     ready_ff      <= 1'b1;
                     cnt_ff        <= '0;
                     sum_ff        <= '0;
                     sq_ff         <= '0;
                     res_status_ff <= ST_ZERO_VAR;
                     state_ff      <= S_EMIT;
                  end else begin
                     div_a_ff  <= DVD_W'(25'h1000000) + DVD_W'(sd_w[15:1]);
                     div_b_ff  <= DVS_W'(sd_w);
                     div_go_ff <= 1'b1;
                     state_ff  <= S_INV;
                  end
               end
            end
            S_INV: begin
               if (div_st.done) begin
                  inv_ff        <= (quot > DVD_W'(24'hFFFFFF)) ? 24'hFFFFFF
                                                               : quot[INV_W-1:0];
                  mean_ff       <= res_value_ff;
                  ready_ff      <= 1'b1;
                  cnt_ff        <= '0;
                  sum_ff        <= '0;
                  sq_ff         <= '0;
                  res_status_ff <= ST_OK;
                  state_ff      <= S_EMIT;
               end
            end
            S_NMUL: begin
               prod_ff  <= d_ff * $signed({1'b0, inv_ff});
               state_ff <= S_NRND;
            end
            S_NRND: begin
               res_value_ff  <= nval_w;
               res_sd_ff     <= '0;
               res_status_ff <= ST_OK;
               state_ff      <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= res_value_ff;
                  rsp_sd_ff     <= res_sd_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_std_dev = rsp_sd_ff;
   assign rsp_status  = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_VOXELS)) else $error("sample count past limit");
   a_stats_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(ready_ff)) else $error("statistics lost");
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({div_go_ff, mul_go_ff, sq_go_ff})) else $error("two units started");
endmodule
